>>> hw/rtl/oas_pkg.sv
package oas_pkg;

    localparam int DigestW     = 160;
    localparam int AddrCharsDf = 16;
    localparam int AddrCharsMx = 32;

    localparam logic [6:0] ROUND_LAST = 7'd79;
    localparam logic [6:0] ROUND_P1   = 7'd20;
    localparam logic [6:0] ROUND_P2   = 7'd40;
    localparam logic [6:0] ROUND_P3   = 7'd60;

    localparam logic [31:0] H_INIT [5] = '{
        32'h67452301, 32'hEFCDAB89, 32'h98BADCFE, 32'h10325476, 32'hC3D2E1F0
    };
    localparam logic [31:0] K_ROUND [4] = '{
        32'h5A827999, 32'h6ED9EBA1, 32'h8F1BBCDC, 32'hCA62C1D6
    };

    localparam logic [7:0] PAD_BYTE = 8'h80;

    // Commands from the sequencer to the datapath.
    typedef struct packed {
        logic       wr_byte;   // absorb the input byte, count it
        logic       wr_pad;    // write the 0x80 pad byte
        logic       wr_len;    // write the bit length into words 14 and 15
        logic       start;     // load working registers from the chain
        logic       round;     // run one compression round
        logic [6:0] round_idx;
        logic       fold;      // add working registers into the chain
        logic       finish;    // fold into the digest, restart the chain
    } t_cmd;

    // Status from the datapath to the sequencer.
    typedef struct packed {
        logic pos_last;   // byte position in block is 63
        logic pos_hi;     // byte position in block is 56 or more
        logic emit_busy;  // character stream still in progress
    } t_stat;

    // Base32 alphabet: a-z then 2-7.
    function automatic logic [7:0] b32_char(input logic [4:0] v);
        logic [7:0] c;
        if (v < 5'd26) begin
            c = 8'h61 + {3'b000, v};
        end else begin
            c = 8'h18 + {3'b000, v};
        end
        return c;
    endfunction

endpackage

>>> hw/rtl/onion_address_sha1_base32.sv
// Channel   Direction  Handshake                  Payload
// input     in         i_in_valid / o_in_ready    i_message_byte, i_message_last
// output    out        o_out_valid / i_out_ready  o_address_char, o_char_position,
//                                                 o_address_last
//
// Rates: one byte per cycle while idle; every 64th byte starts 80 rounds, one per cycle,
//   then a fold step, and input waits until that fold is done.
// Last byte: a pad step (a further block if the pad spills past byte 55), then a length
//   step and the final block before the first character is valid.
// Reset: synchronous, active low; the chain returns to the SHA-1 initial values.
// Stalls: input waits outside idle; the final fold waits for the previous address.
module onion_address_sha1_base32
    import oas_pkg::*;
#(
    parameter int ADDRESS_CHARS = AddrCharsDf
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    // message bytes in
    input  logic       i_in_valid,
    output logic       o_in_ready,
    input  logic [7:0] i_message_byte,
    input  logic       i_message_last,
    // address characters out
    output logic       o_out_valid,
    input  logic       i_out_ready,
    output logic [7:0] o_address_char,
    output logic [3:0] o_char_position,
    output logic       o_address_last
);

    t_cmd  cmd;
    t_stat stat;

    // Sequencer: byte absorb, padding, round count, fold
    oas_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_in_last  (i_message_last),
        .o_in_ready (o_in_ready),
        .o_cmd      (cmd),
        .i_stat     (stat)
    );

    // Datapath: block words, round unit, chain, base32 character stream
    oas_dpath #(
        .ADDRESS_CHARS (ADDRESS_CHARS)
    ) u_dpath (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_message_byte  (i_message_byte),
        .i_cmd           (cmd),
        .o_stat          (stat),
        .o_out_valid     (o_out_valid),
        .i_out_ready     (i_out_ready),
        .o_address_char  (o_address_char),
        .o_char_position (o_char_position),
        .o_address_last  (o_address_last)
    );

endmodule

>>> hw/rtl/oas_ctrl.sv
module oas_ctrl
    import oas_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_in_valid,
    input  logic  i_in_last,
    output logic  o_in_ready,
    output t_cmd  o_cmd,
    input  t_stat i_stat
);

    typedef enum logic [4:0] {
        S_IDLE = 5'b00001,
        S_PAD  = 5'b00010,
        S_LEN  = 5'b00100,
        S_COMP = 5'b01000,
        S_FOLD = 5'b10000
    } t_state;

    typedef enum logic [1:0] {
        RET_IDLE = 2'd0,
        RET_PAD  = 2'd1,
        RET_LEN  = 2'd2,
        RET_FIN  = 2'd3
    } t_ret;

    t_state     r_state, n_state;
    t_ret       r_ret, n_ret;
    logic [6:0] r_round, n_round;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_ret   <= RET_IDLE;
            r_round <= '0;
        end else begin
            r_state <= n_state;
            r_ret   <= n_ret;
            r_round <= n_round;
        end
    end

    always_comb begin
        n_state    = r_state;
        n_ret      = r_ret;
        n_round    = r_round;
        o_cmd      = '0;
        o_in_ready = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.wr_byte = 1'b1;
                    if (i_stat.pos_last) begin
                        o_cmd.start = 1'b1;
                        n_state     = S_COMP;
                        n_ret       = i_in_last ? RET_PAD : RET_IDLE;
                    end else if (i_in_last) begin
                        n_state = S_PAD;
                    end
                end
            end
            S_PAD: begin
                o_cmd.wr_pad = 1'b1;
                if (i_stat.pos_hi) begin
                    o_cmd.start = 1'b1;
                    n_state     = S_COMP;
                    n_ret       = RET_LEN;
                end else begin
                    n_state = S_LEN;
                end
            end
            S_LEN: begin
                o_cmd.wr_len = 1'b1;
                o_cmd.start  = 1'b1;
                n_state      = S_COMP;
                n_ret        = RET_FIN;
            end
            S_COMP: begin
                o_cmd.round     = 1'b1;
                o_cmd.round_idx = r_round;
                if (r_round == ROUND_LAST) begin
                    n_round = '0;
                    n_state = S_FOLD;
                end else begin
                    n_round = r_round + 7'd1;
                end
            end
            S_FOLD: begin
                unique case (r_ret)
                    RET_IDLE: begin
                        o_cmd.fold = 1'b1;
                        n_state    = S_IDLE;
                    end
                    RET_PAD: begin
                        o_cmd.fold = 1'b1;
                        n_state    = S_PAD;
                    end
                    RET_LEN: begin
                        o_cmd.fold = 1'b1;
                        n_state    = S_LEN;
                    end
                    RET_FIN: begin
                        // hold until the previous address has drained
                        if (!i_stat.emit_busy) begin
                            o_cmd.finish = 1'b1;
                            n_state      = S_IDLE;
                            n_ret        = RET_IDLE;
                        end
                    end
                    default: n_state = S_IDLE;
                endcase
            end
            default: n_state = S_IDLE;
        endcase
    end

    a_round_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != S_COMP) |-> (r_round == '0))
        else $error("round counter left nonzero outside compression");

    a_fin_to_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_FOLD && r_ret == RET_FIN && !i_stat.emit_busy)
            |=> (r_state == S_IDLE))
        else $error("final fold did not return to idle");

    a_comp_to_fold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_COMP && r_round == ROUND_LAST) |=> (r_state == S_FOLD))
        else $error("last round did not lead to the fold");

endmodule

>>> hw/rtl/oas_dpath.sv
module oas_dpath
    import oas_pkg::*;
#(
    parameter int ADDRESS_CHARS = AddrCharsDf
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic [7:0] i_message_byte,
    input  t_cmd       i_cmd,
    output t_stat      o_stat,
    output logic       o_out_valid,
    input  logic       i_out_ready,
    output logic [7:0] o_address_char,
    output logic [3:0] o_char_position,
    output logic       o_address_last
);

    localparam int NChars = (ADDRESS_CHARS < 1) ? 1 :
                            ((ADDRESS_CHARS > AddrCharsMx) ? AddrCharsMx : ADDRESS_CHARS);
    localparam int CntW   = ($clog2(NChars) > 4) ? $clog2(NChars) : 4;
    localparam logic [CntW-1:0] CntLast = CntW'(NChars - 1);

    logic [31:0]        r_win [16];
    logic [31:0]        r_chain [5];
    logic [31:0]        r_rnd [5];
    logic [63:0]        r_len;
    logic [DigestW-1:0] r_dig;
    logic [7:0]         r_char;
    logic [CntW-1:0]    r_cnt;
    logic               r_ovalid;
    logic               r_olast;

    logic [5:0]         pos;
    logic [7:0]         put_val;
    logic [31:0]        put_word;
    logic [31:0]        sched_new;
    logic [31:0]        f_val;
    logic [1:0]         k_sel;
    logic [31:0]        t_val;
    logic [DigestW-1:0] digest;
    logic               out_xfer;

    assign pos      = r_len[5:0];
    assign put_val  = i_cmd.wr_pad ? PAD_BYTE : i_message_byte;
    assign put_word = {put_val, 24'h000000} >> {pos[1:0], 3'b000};
    assign out_xfer = r_ovalid && i_out_ready;

    assign o_stat.pos_last  = (pos == 6'd63);
    assign o_stat.pos_hi    = (pos >= 6'd56);
    assign o_stat.emit_busy = r_ovalid;

    // Next schedule word, window holds W[t..t+15]
    assign sched_new = {r_win[13][30:0] ^ r_win[8][30:0] ^ r_win[2][30:0] ^ r_win[0][30:0],
                        r_win[13][31] ^ r_win[8][31] ^ r_win[2][31] ^ r_win[0][31]};

    always_comb begin
        if (i_cmd.round_idx < ROUND_P1) begin
            f_val = (r_rnd[1] & r_rnd[2]) | (~r_rnd[1] & r_rnd[3]);
            k_sel = 2'd0;
        end else if (i_cmd.round_idx < ROUND_P2) begin
            f_val = r_rnd[1] ^ r_rnd[2] ^ r_rnd[3];
            k_sel = 2'd1;
        end else if (i_cmd.round_idx < ROUND_P3) begin
            f_val = (r_rnd[1] & r_rnd[2]) | (r_rnd[1] & r_rnd[3]) | (r_rnd[2] & r_rnd[3]);
            k_sel = 2'd2;
        end else begin
            f_val = r_rnd[1] ^ r_rnd[2] ^ r_rnd[3];
            k_sel = 2'd3;
        end
    end

    assign t_val = {r_rnd[0][26:0], r_rnd[0][31:27]} + f_val + r_rnd[4]
                 + K_ROUND[k_sel] + r_win[0];

    assign digest = {r_chain[0] + r_rnd[0], r_chain[1] + r_rnd[1], r_chain[2] + r_rnd[2],
                     r_chain[3] + r_rnd[3], r_chain[4] + r_rnd[4]};

    // Block words, chain, byte count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < 16; i++) begin
                r_win[i] <= '0;
            end
            for (int i = 0; i < 5; i++) begin
                r_chain[i] <= H_INIT[i];
            end
            r_len <= '0;
        end else begin
            if (i_cmd.fold || i_cmd.finish) begin
                for (int i = 0; i < 16; i++) begin
                    r_win[i] <= '0;
                end
            end else if (i_cmd.round) begin
                for (int i = 0; i < 15; i++) begin
                    r_win[i] <= r_win[i+1];
                end
                r_win[15] <= sched_new;
            end else if (i_cmd.wr_len) begin
                r_win[14] <= r_len[60:29];
                r_win[15] <= {r_len[28:0], 3'b000};
            end else if (i_cmd.wr_byte || i_cmd.wr_pad) begin
                r_win[pos[5:2]] <= r_win[pos[5:2]] | put_word;
            end

            if (i_cmd.finish) begin
                for (int i = 0; i < 5; i++) begin
                    r_chain[i] <= H_INIT[i];
                end
            end else if (i_cmd.fold) begin
                for (int i = 0; i < 5; i++) begin
                    r_chain[i] <= r_chain[i] + r_rnd[i];
                end
            end

            if (i_cmd.finish) begin
                r_len <= '0;
            end else if (i_cmd.wr_byte) begin
                r_len <= r_len + 64'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.start) begin
            for (int i = 0; i < 5; i++) begin
                r_rnd[i] <= r_chain[i];
            end
        end else if (i_cmd.round) begin
            r_rnd[4] <= r_rnd[3];
            r_rnd[3] <= r_rnd[2];
            r_rnd[2] <= {r_rnd[1][1:0], r_rnd[1][31:2]};
            r_rnd[1] <= r_rnd[0];
            r_rnd[0] <= t_val;
        end
    end

    // Character stream: five digest bits per transfer, most significant first
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovalid <= 1'b0;
        end else if (i_cmd.finish) begin
            r_ovalid <= 1'b1;
        end else if (out_xfer && r_olast) begin
            r_ovalid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.finish) begin
            r_char  <= b32_char(digest[DigestW-1 -: 5]);
            r_dig   <= digest << 5;
            r_cnt   <= '0;
            r_olast <= (NChars == 1);
        end else if (out_xfer && !r_olast) begin
            r_char  <= b32_char(r_dig[DigestW-1 -: 5]);
            r_dig   <= r_dig << 5;
            r_cnt   <= r_cnt + 1'b1;
            r_olast <= ((r_cnt + 1'b1) == CntLast);
        end
    end

    assign o_out_valid     = r_ovalid;
    assign o_address_char  = r_char;
    assign o_char_position = r_cnt[3:0];
    assign o_address_last  = r_olast;

    a_load_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.finish |-> !r_ovalid)
        else $error("digest loaded while characters still pending");

    a_stream_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (out_xfer && r_olast) |=> !o_out_valid)
        else $error("stream continued past its last character");

    a_win_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.fold || i_cmd.finish) |=> (r_win[0] == '0 && r_win[15] == '0))
        else $error("block words not cleared after compression");

endmodule

>>> test/onion_address_sha1_base32_checker.sv
module onion_address_sha1_base32_checker #(
    parameter int ADDRESS_CHARS = 16
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    input  logic       i_in_ready,
    input  logic [7:0] i_message_byte,
    input  logic       i_message_last,
    input  logic       i_out_valid,
    input  logic       i_out_ready,
    input  logic [7:0] i_address_char,
    input  logic [3:0] i_char_position,
    input  logic       i_address_last,
    output int         o_fail_count,
    output int         o_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int N_CHARS = (ADDRESS_CHARS < 1) ? 1 :
                             (ADDRESS_CHARS > 32) ? 32 : ADDRESS_CHARS;
    localparam int REPORT_MAX = 10;

    localparam logic [31:0] IV0 = 32'h67452301;
    localparam logic [31:0] IV1 = 32'hEFCDAB89;
    localparam logic [31:0] IV2 = 32'h98BADCFE;
    localparam logic [31:0] IV3 = 32'h10325476;
    localparam logic [31:0] IV4 = 32'hC3D2E1F0;
    localparam logic [31:0] K_00_19 = 32'h5A827999;
    localparam logic [31:0] K_20_39 = 32'h6ED9EBA1;
    localparam logic [31:0] K_40_59 = 32'h8F1BBCDC;
    localparam logic [31:0] K_60_79 = 32'hCA62C1D6;
    localparam logic [255:0] B32_ALPHABET = "abcdefghijklmnopqrstuvwxyz234567";

    typedef struct packed {
        logic [7:0] ch;
        logic [3:0] pos;
        logic       last;
    } t_addr_char;

    t_addr_char  chars_due [$];
    logic [31:0] block_w [16];
    logic [31:0] chain_h [5];
    logic [63:0] byte_count;

    function automatic logic [31:0] rol(input logic [31:0] x, input int n);
        return (x << n) | (x >> (32 - n));
    endfunction

    function automatic void restart_hash();
        int i;
        for (i = 0; i < 16; i++) block_w[i] = '0;
        chain_h[0] = IV0;
        chain_h[1] = IV1;
        chain_h[2] = IV2;
        chain_h[3] = IV3;
        chain_h[4] = IV4;
        byte_count = '0;
    endfunction

    // One SHA-1 block: 80 rounds on the rolling 16-word schedule, fold into the chain.
    function automatic void sha1_compress();
        logic [31:0] a, b, c, d, e, f, kc, w, t;
        int r;
        a = chain_h[0];
        b = chain_h[1];
        c = chain_h[2];
        d = chain_h[3];
        e = chain_h[4];
        for (r = 0; r < 80; r++) begin
            if (r >= 16) begin
                w = block_w[(r - 3) & 15] ^ block_w[(r - 8) & 15]
                  ^ block_w[(r - 14) & 15] ^ block_w[r & 15];
                block_w[r & 15] = rol(w, 1);
            end
            w = block_w[r & 15];
            if (r < 20) begin
                f  = (b & c) | (~b & d);
                kc = K_00_19;
            end else if (r < 40) begin
                f  = b ^ c ^ d;
                kc = K_20_39;
            end else if (r < 60) begin
                f  = (b & c) | (b & d) | (c & d);
                kc = K_40_59;
            end else begin
                f  = b ^ c ^ d;
                kc = K_60_79;
            end
            t = rol(a, 5) + f + e + kc + w;
            e = d;
            d = c;
            c = rol(b, 30);
            b = a;
            a = t;
        end
        chain_h[0] += a;
        chain_h[1] += b;
        chain_h[2] += c;
        chain_h[3] += d;
        chain_h[4] += e;
        for (r = 0; r < 16; r++) block_w[r] = '0;
    endfunction

    function automatic void place_byte(input logic [5:0] pos, input logic [7:0] b);
        block_w[pos[5:2]] |= {24'd0, b} << (24 - 8 * pos[1:0]);
    endfunction

    // Absorb one message byte; on the last one, pad, finish and queue the address.
    function automatic void hash_byte(input logic [7:0] b, input logic last);
        logic [5:0]   pos;
        logic [63:0]  bit_len;
        logic [159:0] digest;
        logic [4:0]   v;
        t_addr_char   c;
        int k;
        pos = byte_count[5:0];
        place_byte(pos, b);
        byte_count++;
        if (pos == 6'd63) sha1_compress();
        if (!last) return;
        pos = byte_count[5:0];
        place_byte(pos, 8'h80);
        if (pos >= 6'd56) sha1_compress();
        bit_len = byte_count << 3;
        block_w[14] = bit_len[63:32];
        block_w[15] = bit_len[31:0];
        sha1_compress();
        digest = {chain_h[0], chain_h[1], chain_h[2], chain_h[3], chain_h[4]};
        for (k = 0; k < N_CHARS; k++) begin
            v      = digest[159 - 5 * k -: 5];
            c.ch   = B32_ALPHABET[8 * (31 - v) +: 8];
            c.pos  = k[3:0];
            c.last = (k == N_CHARS - 1);
            chars_due.push_back(c);
        end
        restart_hash();
    endfunction

    function automatic void flag_error(input string what, input t_addr_char want);
        o_fail_count++;
        if (o_fail_count <= REPORT_MAX) begin
            $display("%0t: %s: expected char %h pos %0d last %b, got char %h pos %0d last %b",
                     $realtime, what, want.ch, want.pos, want.last,
                     i_address_char, i_char_position, i_address_last);
        end
    endfunction

    always @(posedge i_clk) begin
        t_addr_char want;
        if (!i_rst_n) begin
            restart_hash();
            chars_due.delete();
            o_fail_count = 0;
        end else begin
            if (i_in_valid && i_in_ready) hash_byte(i_message_byte, i_message_last);
            if (i_out_valid && i_out_ready) begin
                if (chars_due.size() == 0) begin
                    want = '0;
                    flag_error("unexpected character", want);
                end else begin
                    want = chars_due.pop_front();
                    if (i_address_char !== want.ch || i_char_position !== want.pos
                        || i_address_last !== want.last) begin
                        flag_error("character mismatch", want);
                    end
                end
            end
        end
        o_pending = chars_due.size();
    end

endmodule

>>> test/tb_onion_address_sha1_base32.sv
module tb_onion_address_sha1_base32;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int ADDR_CHARS     = 16;
    localparam int TOTAL_BYTES    = 470;   // stop starting new messages past this
    localparam int PHASE_BYTES    = 160;   // bytes per idling phase
    localparam int HOLD_AT_BYTES  = 340;   // where the long receiver hold-off starts
    localparam int HOLD_CYCLES    = 1500;
    localparam int DRAIN_CYCLES   = 200;   // covers one final block plus padding block
    localparam int WATCHDOG_LIMIT = 20000; // cycles without any transfer

    logic       i_clk = 1'b0;
    logic       i_rst_n = 1'b0;
    logic       i_in_valid = 1'b0;
    logic       o_in_ready;
    logic [7:0] i_message_byte = 8'h00;
    logic       i_message_last = 1'b0;
    logic       o_out_valid;
    logic       i_out_ready = 1'b0;
    logic [7:0] o_address_char;
    logic [3:0] o_char_position;
    logic       o_address_last;

    int fail_count;
    int chars_pending;
    int bytes_sent = 0;
    int in_xfers = 0;
    int send_idle_pct = 20;
    int recv_idle_pct = 63;
    int hold_left = 0;
    logic hold_done = 1'b0;
    int stall_cycles = 0;

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    onion_address_sha1_base32 #(
        .ADDRESS_CHARS(ADDR_CHARS)
    ) uut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .o_in_ready     (o_in_ready),
        .i_message_byte (i_message_byte),
        .i_message_last (i_message_last),
        .o_out_valid    (o_out_valid),
        .i_out_ready    (i_out_ready),
        .o_address_char (o_address_char),
        .o_char_position(o_char_position),
        .o_address_last (o_address_last)
    );

    onion_address_sha1_base32_checker #(
        .ADDRESS_CHARS(ADDR_CHARS)
    ) address_check (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .i_in_ready     (o_in_ready),
        .i_message_byte (i_message_byte),
        .i_message_last (i_message_last),
        .i_out_valid    (o_out_valid),
        .i_out_ready    (i_out_ready),
        .i_address_char (o_address_char),
        .i_char_position(o_char_position),
        .i_address_last (o_address_last),
        .o_fail_count   (fail_count),
        .o_pending      (chars_pending)
    );

    // Count byte transfers from the handshake itself, so the hold-off trigger
    // does not depend on process ordering within a time step.
    always @(posedge i_clk) begin
        if (i_rst_n && i_in_valid && o_in_ready) in_xfers <= in_xfers + 1;
    end

    // Character receiver: random stalls at the current rate, plus one long
    // hold-off so the output register and then the input side back up.
    always @(posedge i_clk) begin
        if (hold_left > 0) begin
            hold_left   <= hold_left - 1;
            i_out_ready <= 1'b0;
        end else if (!hold_done && in_xfers >= HOLD_AT_BYTES) begin
            hold_left   <= HOLD_CYCLES;
            hold_done   <= 1'b1;
            i_out_ready <= 1'b0;
        end else begin
            i_out_ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    // Watchdog: end the run if neither channel moves for too long.
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_in_valid && o_in_ready) || (o_out_valid && i_out_ready)) begin
            stall_cycles <= 0;
        end else if (stall_cycles >= WATCHDOG_LIMIT) begin
            $display("CHECKS FAILED");
            $finish;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
    end

    // Offer one byte and hold it until the transfer. Drop valid only for an
    // idle gap; never lower and raise it in the same step.
    task automatic send_byte(input logic [7:0] b, input logic last);
        while ($urandom_range(99) < send_idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid     <= 1'b1;
        i_message_byte <= b;
        i_message_last <= last;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
        bytes_sent++;
    endtask

    // Send a whole message; fill selects random bytes, all zero or all ones.
    task automatic send_message(input int len, input int fill);
        logic [7:0] b;
        int i;
        for (i = 0; i < len; i++) begin
            case (fill)
                0: b = 8'h00;
                1: b = 8'hFF;
                default: b = 8'($urandom);
            endcase
            send_byte(b, i == len - 1);
        end
    endtask

    // Pick a message length: mostly short, some right at the padding and
    // block boundaries (pad fits, pad spills, exact block, two blocks).
    function automatic int pick_length();
        int sel;
        int edges [9];
        edges = '{55, 56, 57, 63, 64, 65, 119, 120, 128};
        sel = $urandom_range(9);
        if (sel < 4) return $urandom_range(8, 1);
        if (sel < 6) return edges[$urandom_range(8)];
        return $urandom_range(100, 1);
    endfunction

    initial begin
        int fill;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: one-byte messages at the byte extremes, the classic "abc"
        // vector, and short multi-byte messages where earlier bytes are absorbed
        // silently; every bit of the byte toggles.
        send_byte(8'h00, 1'b1);
        send_byte(8'hFF, 1'b1);
        send_byte(8'h61, 1'b0);
        send_byte(8'h62, 1'b0);
        send_byte(8'h63, 1'b1);
        send_byte(8'h80, 1'b0);
        send_byte(8'h7F, 1'b0);
        send_byte(8'h01, 1'b0);
        send_byte(8'hFE, 1'b1);
        send_byte(8'hAA, 1'b0);
        send_byte(8'h55, 1'b1);

        // Random messages; swap the idle rates after the first phase, then run flat out.
        while (bytes_sent < TOTAL_BYTES) begin
            if (bytes_sent >= 2 * PHASE_BYTES) begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end else if (bytes_sent >= PHASE_BYTES) begin
                send_idle_pct = 63;
                recv_idle_pct = 20;
            end
            fill = ($urandom_range(9) == 0) ? $urandom_range(1) : 2;
            send_message(pick_length(), fill);
        end
        i_in_valid <= 1'b0;

        // Let the checker see the last transfer, then drain the address queue.
        @(posedge i_clk);
        while (chars_pending != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (fail_count == 0 && chars_pending == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule

>>> onion_address_sha1_base32.f
hw/rtl/oas_pkg.sv
hw/rtl/oas_ctrl.sv
hw/rtl/oas_dpath.sv
hw/rtl/onion_address_sha1_base32.sv
test/onion_address_sha1_base32_checker.sv
test/tb_onion_address_sha1_base32.sv
